// ===== design/sdi_anc_pkg.sv =====
package sdi_anc_pkg;

   // parser phase, one step per received byte
   typedef enum logic [3:0] {
      PH_WAIT    = 4'd0,
      PH_LOCHI   = 4'd1,
      PH_LOCLO   = 4'd2,
      PH_DID     = 4'd3,
      PH_SDID    = 4'd4,
      PH_COUNT   = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CHECK   = 4'd7,
      PH_HALT    = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      KIND_WORD  = 2'd0,
      KIND_END   = 2'd1,
      KIND_TRUNC = 2'd2
   } kind_type;

   localparam logic [7:0] START_BYTE = 8'hff;

   // result fields, last member in the lowest bits
   typedef struct packed {
      logic        checksum_bad;
      logic        chroma_stream;
      logic        horizontal_space;
      logic [7:0]  word_count;
      logic [7:0]  secondary_id;
      logic [7:0]  data_id;
      logic [10:0] line_number;
      logic [7:0]  word_index;
      logic [9:0]  user_word;
   } result_type;

   localparam int RESULT_BITS = $bits(result_type);

   // payload byte with bit 8 set for odd popcount, bit 9 otherwise
   function automatic logic [9:0] parity_word(input logic [7:0] b);
      parity_word = (^b) ? {2'b01, b} : {2'b10, b};
   endfunction

endpackage

// ===== design/sdi_anc_packet_parser.sv =====
// Ancillary packet parser for an extractor byte stream. One byte is taken per
// transfer on req_ (tlast marks the last byte of a field's stream); packets are
// 0xff, two location bytes, DID, SDID, data count, payload and checksum. Each
// payload byte gives a 10-bit user word (kind 0), the checksum byte gives a
// packet-end record with a checksum-error flag (kind 1), and a packet left open
// at the end of the stream gives a truncated marker (kind 2). A bad start byte
// stops parsing until the end of the stream. The block takes one byte every
// cycle while req_tready is high; each result is registered. The next-state and
// result logic is a single phase step plus one 8-bit add, between the parser
// state registers and the result register; a skid register behind the result
// register takes one more result while rsp_tready is low (bytes that give no
// result keep flowing), after which req_tready drops until the skid register
// drains.
module sdi_anc_packet_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // stream_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // user_word[9:0], word_index, line_number, data_id, secondary_id,
   // word_count, horizontal_space, chroma_stream, checksum_bad
   output logic [55:0] rsp_tdata,
   output logic [1:0]  rsp_tuser    // result_kind
);

   // parser state
   sdi_anc_pkg::phase_type phase_ff, phase_in, phase_step;
   logic [7:0] loc_hi_ff, loc_hi_in;
   logic [6:0] loc_lo_ff, loc_lo_in;
   logic [7:0] did_ff, did_in;
   logic [7:0] sdid_ff, sdid_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] seen_ff, seen_in;
   logic [7:0] sum_ff, sum_in;

   // result and skid registers
   logic                    out_valid_ff, out_valid_in;
   sdi_anc_pkg::result_type out_data_ff, out_data_in;
   sdi_anc_pkg::kind_type   out_kind_ff, out_kind_in;
   logic                    skid_valid_ff, skid_valid_in;
   sdi_anc_pkg::result_type skid_data_ff, skid_data_in;
   sdi_anc_pkg::kind_type   skid_kind_ff, skid_kind_in;

   // result of the byte at the input
   logic                    res_valid;
   logic                    res_trunc;
   sdi_anc_pkg::kind_type   res_kind;
   sdi_anc_pkg::result_type res_data;

   logic req_xfer, rsp_xfer;

   assign req_tready = !skid_valid_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   // phase step and header holds
   always_comb begin
      phase_step = phase_ff;
      loc_hi_in  = loc_hi_ff;
      loc_lo_in  = loc_lo_ff;
      did_in     = did_ff;
      sdid_in    = sdid_ff;
      count_in   = count_ff;
      seen_in    = seen_ff;
      sum_in     = sum_ff;
      unique case (phase_ff)
         sdi_anc_pkg::PH_WAIT: begin
            if (req_tdata == sdi_anc_pkg::START_BYTE) begin
               loc_hi_in  = '0;
               loc_lo_in  = '0;
               did_in     = '0;
               sdid_in    = '0;
               count_in   = '0;
               seen_in    = '0;
               sum_in     = '0;
               phase_step = sdi_anc_pkg::PH_LOCHI;
            end else begin
               phase_step = sdi_anc_pkg::PH_HALT;
            end
         end
         sdi_anc_pkg::PH_LOCHI: begin
            loc_hi_in  = req_tdata;
            phase_step = sdi_anc_pkg::PH_LOCLO;
         end
         sdi_anc_pkg::PH_LOCLO: begin
            loc_lo_in  = req_tdata[6:0];
            phase_step = sdi_anc_pkg::PH_DID;
         end
         sdi_anc_pkg::PH_DID: begin
            did_in     = req_tdata;
            sum_in     = req_tdata;
            phase_step = sdi_anc_pkg::PH_SDID;
         end
         sdi_anc_pkg::PH_SDID: begin
            sdid_in    = req_tdata;
            sum_in     = sum_ff + req_tdata;
            phase_step = sdi_anc_pkg::PH_COUNT;
         end
         sdi_anc_pkg::PH_COUNT: begin
            count_in   = req_tdata;
            sum_in     = sum_ff + req_tdata;
            phase_step = (req_tdata != 8'd0) ? sdi_anc_pkg::PH_PAYLOAD
                                             : sdi_anc_pkg::PH_CHECK;
         end
         sdi_anc_pkg::PH_PAYLOAD: begin
            // the last byte of the stream is not taken as payload
            if (!req_tlast) begin
               sum_in  = sum_ff + req_tdata;
               seen_in = seen_ff + 8'd1;
               if (seen_in == count_ff) begin
                  phase_step = sdi_anc_pkg::PH_CHECK;
               end
            end
         end
         sdi_anc_pkg::PH_CHECK: begin
            phase_step = sdi_anc_pkg::PH_WAIT;
         end
         default: begin
            phase_step = sdi_anc_pkg::PH_HALT;
         end
      endcase
   end

   // a packet still open at the end of the stream is abandoned
   always_comb begin
      case (phase_step) inside
         sdi_anc_pkg::PH_LOCHI, sdi_anc_pkg::PH_LOCLO, sdi_anc_pkg::PH_DID,
         sdi_anc_pkg::PH_SDID, sdi_anc_pkg::PH_COUNT, sdi_anc_pkg::PH_PAYLOAD,
         sdi_anc_pkg::PH_CHECK: res_trunc = req_tlast;
         default:               res_trunc = 1'b0;
      endcase
      phase_in = req_tlast ? sdi_anc_pkg::PH_WAIT : phase_step;
   end

   // result fields
   always_comb begin
      res_valid = 1'b0;
      res_kind  = sdi_anc_pkg::KIND_WORD;
      res_data.user_word        = '0;
      res_data.word_index       = '0;
      res_data.checksum_bad     = 1'b0;
      res_data.line_number      = {loc_hi_in[3:0], loc_lo_in};
      res_data.data_id          = did_in;
      res_data.secondary_id     = sdid_in;
      res_data.word_count       = count_in;
      res_data.horizontal_space = loc_hi_in[7] && loc_hi_in[4];
      res_data.chroma_stream    = loc_hi_in[7] && !loc_hi_in[5];
      if (res_trunc) begin
         res_valid           = 1'b1;
         res_kind            = sdi_anc_pkg::KIND_TRUNC;
         res_data.word_index = seen_in;
      end else if (phase_ff == sdi_anc_pkg::PH_PAYLOAD) begin
         res_valid           = 1'b1;
         res_kind            = sdi_anc_pkg::KIND_WORD;
         res_data.user_word  = sdi_anc_pkg::parity_word(req_tdata);
         res_data.word_index = seen_ff;
      end else if (phase_ff == sdi_anc_pkg::PH_CHECK) begin
         res_valid             = 1'b1;
         res_kind              = sdi_anc_pkg::KIND_END;
         res_data.checksum_bad = (req_tdata != sum_ff);
      end
   end

   // result register with skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      out_kind_in   = out_kind_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_kind_in  = skid_kind_ff;
      if (skid_valid_ff) begin
         if (rsp_xfer) begin
            out_data_in   = skid_data_ff;
            out_kind_in   = skid_kind_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_xfer && res_valid) begin
         if (!out_valid_ff || rsp_xfer) begin
            out_valid_in = 1'b1;
            out_data_in  = res_data;
            out_kind_in  = res_kind;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res_data;
            skid_kind_in  = res_kind;
         end
      end else if (rsp_xfer) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= sdi_anc_pkg::PH_WAIT;
         loc_hi_ff     <= '0;
         loc_lo_ff     <= '0;
         did_ff        <= '0;
         sdid_ff       <= '0;
         count_ff      <= '0;
         seen_ff       <= '0;
         sum_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            phase_ff  <= phase_in;
            loc_hi_ff <= loc_hi_in;
            loc_lo_ff <= loc_lo_in;
            did_ff    <= did_in;
            sdid_ff   <= sdid_in;
            count_ff  <= count_in;
            seen_ff   <= seen_in;
            sum_ff    <= sum_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      out_kind_ff  <= out_kind_in;
      skid_data_ff <= skid_data_in;
      skid_kind_ff <= skid_kind_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;

   // skid stage only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while result register empty");

   // in payload the count of words sent stays below the data count
   a_seen_below_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == sdi_anc_pkg::PH_PAYLOAD) |-> (seen_ff < count_ff))
      else $error("payload word count reached data count without leaving payload");

   // payload words carry an index below the packet's data count
   a_word_index_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == sdi_anc_pkg::KIND_WORD)
         |-> (out_data_ff.word_index < out_data_ff.word_count))
      else $error("payload word index out of range");

   // only packet-end records flag a checksum error; only payload words carry a user word
   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff != sdi_anc_pkg::KIND_WORD)
         |-> (out_data_ff.user_word == 10'd0))
      else $error("non-payload result carries a user word");

   // a held result does not change while the skid stage fills
   a_hold_under_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_data_ff)))
      else $error("stalled result changed");

endmodule

// ===== tb/sv/sdi_anc_packet_checker.sv =====
`timescale 1ns / 1ps
module sdi_anc_packet_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          mismatch_count,
   output int          results_due
);

   typedef struct packed {
      sdi_anc_pkg::kind_type   kind;
      sdi_anc_pkg::result_type fields;
   } anc_result_type;

   // words and records still owed by the parser, oldest first
   anc_result_type anc_results_due[$];

   // parser state as tracked on the stream side
   sdi_anc_pkg::phase_type phase_q;
   logic [7:0] loc_hi;
   logic [6:0] loc_lo;
   logic [7:0] did_q;
   logic [7:0] sdid_q;
   logic [7:0] count_q;
   logic [7:0] seen_q;
   logic [7:0] sum_q;

   anc_result_type got_q;

   function automatic anc_result_type anc_record(input sdi_anc_pkg::kind_type kind,
                                                 input logic [9:0] word,
                                                 input logic [7:0] idx, input logic bad);
      anc_result_type r;
      r.kind                    = kind;
      r.fields.user_word        = word;
      r.fields.word_index       = idx;
      r.fields.line_number      = {loc_hi[3:0], loc_lo};
      r.fields.data_id          = did_q;
      r.fields.secondary_id     = sdid_q;
      r.fields.word_count       = count_q;
      r.fields.horizontal_space = loc_hi[7] & loc_hi[4];
      r.fields.chroma_stream    = loc_hi[7] & ~loc_hi[5];
      r.fields.checksum_bad     = bad;
      return r;
   endfunction

   function automatic string anc_text(input anc_result_type r);
      return $sformatf("kind %0d word %h idx %0d line %0d did %h sdid %h dc %0d h %b c %b bad %b",
                       r.kind, r.fields.user_word, r.fields.word_index, r.fields.line_number,
                       r.fields.data_id, r.fields.secondary_id, r.fields.word_count,
                       r.fields.horizontal_space, r.fields.chroma_stream,
                       r.fields.checksum_bad);
   endfunction

   task automatic clear_packet();
      loc_hi  = '0;
      loc_lo  = '0;
      did_q   = '0;
      sdid_q  = '0;
      count_q = '0;
      seen_q  = '0;
      sum_q   = '0;
   endtask

   // one stream byte through the parser phases
   task automatic track_anc_byte(input logic [7:0] data_b, input logic end_flag);
      logic [9:0] word;
      word = {2'b00, data_b};
      if (^data_b) word[8] = 1'b1;
      else word[9] = 1'b1;
      case (phase_q)
         sdi_anc_pkg::PH_WAIT: begin
            if (data_b == sdi_anc_pkg::START_BYTE) begin
               clear_packet();
               phase_q = sdi_anc_pkg::PH_LOCHI;
            end else begin
               phase_q = sdi_anc_pkg::PH_HALT;
            end
         end
         sdi_anc_pkg::PH_LOCHI: begin
            loc_hi  = data_b;
            phase_q = sdi_anc_pkg::PH_LOCLO;
         end
         sdi_anc_pkg::PH_LOCLO: begin
            loc_lo  = data_b[6:0];
            phase_q = sdi_anc_pkg::PH_DID;
         end
         sdi_anc_pkg::PH_DID: begin
            did_q   = data_b;
            sum_q   = data_b;
            phase_q = sdi_anc_pkg::PH_SDID;
         end
         sdi_anc_pkg::PH_SDID: begin
            sdid_q  = data_b;
            sum_q   = sum_q + data_b;
            phase_q = sdi_anc_pkg::PH_COUNT;
         end
         sdi_anc_pkg::PH_COUNT: begin
            count_q = data_b;
            sum_q   = sum_q + data_b;
            phase_q = (data_b != 8'd0) ? sdi_anc_pkg::PH_PAYLOAD : sdi_anc_pkg::PH_CHECK;
         end
         sdi_anc_pkg::PH_PAYLOAD: begin
            // the closing byte of a stream never becomes a word
            if (!end_flag) begin
               sum_q = sum_q + data_b;
               anc_results_due.push_back(
                  anc_record(sdi_anc_pkg::KIND_WORD, word, seen_q, 1'b0));
               seen_q = seen_q + 8'd1;
               if (seen_q == count_q) phase_q = sdi_anc_pkg::PH_CHECK;
            end
         end
         sdi_anc_pkg::PH_CHECK: begin
            anc_results_due.push_back(
               anc_record(sdi_anc_pkg::KIND_END, 10'd0, 8'd0, data_b != sum_q));
            phase_q = sdi_anc_pkg::PH_WAIT;
         end
         default: phase_q = sdi_anc_pkg::PH_HALT;
      endcase
      if (end_flag) begin
         if (phase_q >= sdi_anc_pkg::PH_LOCHI && phase_q <= sdi_anc_pkg::PH_CHECK)
            anc_results_due.push_back(
               anc_record(sdi_anc_pkg::KIND_TRUNC, 10'd0, seen_q, 1'b0));
         phase_q = sdi_anc_pkg::PH_WAIT;
      end
   endtask

   task automatic check_result(input anc_result_type got);
      anc_result_type want;
      if (anc_results_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("unexpected result: %s", anc_text(got));
      end else begin
         want = anc_results_due.pop_front();
         if (got.kind !== want.kind
             || got.fields.user_word !== want.fields.user_word
             || got.fields.word_index !== want.fields.word_index
             || got.fields.line_number !== want.fields.line_number
             || got.fields.data_id !== want.fields.data_id
             || got.fields.secondary_id !== want.fields.secondary_id
             || got.fields.word_count !== want.fields.word_count
             || got.fields.horizontal_space !== want.fields.horizontal_space
             || got.fields.chroma_stream !== want.fields.chroma_stream
             || got.fields.checksum_bad !== want.fields.checksum_bad) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("mismatch at %0t: expected %s", $realtime, anc_text(want));
               $display("             actual   %s", anc_text(got));
            end
         end
      end
   endtask

   // results are checked before the byte of the same edge is tracked
   always @(posedge clock) begin
      if (reset) begin
         clear_packet();
         phase_q = sdi_anc_pkg::PH_WAIT;
         anc_results_due.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_q.kind   = sdi_anc_pkg::kind_type'(rsp_tuser);
            got_q.fields = rsp_tdata;
            check_result(got_q);
         end
         if (req_tvalid && req_tready) track_anc_byte(req_tdata, req_tlast);
      end
      results_due = anc_results_due.size();
   end

endmodule

// ===== tb/sv/sdi_anc_packet_parser_tb.sv =====
`timescale 1ns / 1ps
module sdi_anc_packet_parser_tb;

   localparam int STREAM_BYTES = 1200;   // random part, roughly
   localparam int CALM_BYTES   = 250;    // stretch with no idling on either side
   localparam int HOLD_CYCLES  = 160;    // long receiver hold-off
   localparam int CYCLE_LIMIT  = 200000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // data_byte
   logic        req_tlast;   // stream_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   // user_word, word_index, line_number, data_id, secondary_id,
   // word_count, horizontal_space, chroma_stream, checksum_bad
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;   // result_kind

   int mismatch_count;
   int results_due;
   int cycle_count = 0;
   int bytes_sent  = 0;
   bit idle_on;
   bit hold_request;

   // bytes of the field stream being built, tlast goes on the final one
   logic [7:0] field_bytes[$];

   sdi_anc_packet_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   sdi_anc_packet_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // one transfer on req_, with an optional random gap in front of it
   task automatic send_byte(input logic [7:0] data_b, input logic end_flag);
      if (idle_on) begin
         while ($urandom_range(99) < 35) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data_b;
      req_tlast  <= end_flag;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_field();
      for (int i = 0; i < field_bytes.size(); i++)
         send_byte(field_bytes[i], i == field_bytes.size() - 1);
      field_bytes.delete();
   endtask

   // sender pause: nothing offered until every owed result has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (results_due != 0) @(negedge clock);
   endtask

   // mostly short packets, some medium, a rare near-full one
   function automatic int pick_count();
      int r;
      r = $urandom_range(99);
      if (r < 3) return $urandom_range(200, 255);
      if (r < 25) return $urandom_range(9, 40);
      return $urandom_range(0, 8);
   endfunction

   // packet with random header and payload, checksum optionally corrupted
   task automatic queue_packet(input int count, input bit bad_sum);
      logic [7:0] did_b;
      logic [7:0] sdid_b;
      logic [7:0] data_b;
      logic [7:0] sum;
      did_b  = 8'($urandom);
      sdid_b = 8'($urandom);
      sum    = did_b + sdid_b + 8'(count);
      field_bytes.push_back(sdi_anc_pkg::START_BYTE);
      field_bytes.push_back(8'($urandom));   // location high
      field_bytes.push_back(8'($urandom));   // location low
      field_bytes.push_back(did_b);
      field_bytes.push_back(sdid_b);
      field_bytes.push_back(8'(count));
      for (int i = 0; i < count; i++) begin
         data_b = 8'($urandom);
         sum    = sum + data_b;
         field_bytes.push_back(data_b);
      end
      field_bytes.push_back(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
   endtask

   // one field stream: a few packets, then a clean end or a broken tail
   task automatic random_field();
      int n_pkts;
      int pkt_start;
      int cut;
      int mode;
      n_pkts = $urandom_range(1, 4);
      pkt_start = 0;
      for (int i = 0; i < n_pkts; i++) begin
         pkt_start = field_bytes.size();
         queue_packet(pick_count(), $urandom_range(99) < 20);
      end
      mode = $urandom_range(99);
      if (mode < 15) begin
         // stream ends somewhere inside the last packet
         cut = $urandom_range(pkt_start, field_bytes.size() - 2);
         while (field_bytes.size() > cut + 1) void'(field_bytes.pop_back());
      end else if (mode < 28) begin
         // bad start byte, then junk that must be ignored
         field_bytes.push_back(8'($urandom_range(0, 254)));
         repeat ($urandom_range(0, 5)) field_bytes.push_back(8'($urandom));
      end else if (mode < 34) begin
         // lone start byte closes the stream
         field_bytes.push_back(sdi_anc_pkg::START_BYTE);
      end
      send_field();
   endtask

   // rsp_ side: random stalls, or a long hold-off when asked
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready <= !idle_on || ($urandom_range(99) >= 35);
            @(negedge clock);
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      idle_on      = 1'b1;
      hold_request = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // HANC chroma packet with payload extremes, then a zero-count packet
      // with a wrong checksum, masked location low and the stream end on it
      field_bytes = '{8'hff, 8'h90, 8'h85, 8'h41, 8'h07, 8'h02, 8'h00, 8'hff, 8'h49,
                      8'hff, 8'h2f, 8'hff, 8'hff, 8'hff, 8'h00, 8'hfd};
      send_field();
      // bad start byte stops parsing until the end of the stream
      field_bytes = '{8'h5a, 8'h12, 8'h34};
      send_field();
      // lone start byte as the last byte of a stream
      field_bytes = '{8'hff};
      send_field();
      // stream end on a payload byte gives a truncated marker
      field_bytes = '{8'hff, 8'ha0, 8'h01, 8'h60, 8'h60, 8'h05, 8'h33, 8'h44};
      send_field();
      wait_drained();

      // no idling on either side for a while
      idle_on = 1'b0;
      while (bytes_sent < CALM_BYTES) random_field();
      idle_on = 1'b1;

      // receiver holds off while the sender keeps offering
      hold_request = 1'b1;
      while (hold_request) random_field();
      wait_drained();

      while (bytes_sent < STREAM_BYTES) random_field();
      wait_drained();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && results_due == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== sdi_anc_packet_parser.f =====
design/sdi_anc_pkg.sv
design/sdi_anc_packet_parser.sv
tb/sv/sdi_anc_packet_checker.sv
tb/sv/sdi_anc_packet_parser_tb.sv
